/* rtl/core/fscs_pkg.sv */
package fscs_pkg;

	typedef enum logic [1:0] {
		ACT_EXEC  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_WRITE = 2'd2,
		ACT_RESET = 2'd3
	} action_t;

	localparam logic [1:0] CFG_DSP_RESET = 2'd0;
	localparam logic [1:0] CFG_RSP_RESET = 2'd1;
	localparam logic [1:0] CFG_IPF       = 2'd2;
	localparam logic [1:0] CFG_FRAME     = 2'd3;

	localparam logic [3:0] KIND_CALL   = 4'h8;
	localparam logic [3:0] KIND_BRANCH = 4'h9;
	localparam logic [3:0] KIND_BZERO  = 4'hA;
	localparam logic [3:0] KIND_PRIM   = 4'hF;

	localparam logic [7:0] P_FETCH = 8'd0;
	localparam logic [7:0] P_STORE = 8'd1;
	localparam logic [7:0] P_CFETCH = 8'd2;
	localparam logic [7:0] P_CSTORE = 8'd3;
	localparam logic [7:0] P_PSTORE = 8'd4;
	localparam logic [7:0] P_ADD = 8'd5;
	localparam logic [7:0] P_SUB = 8'd6;
	localparam logic [7:0] P_MUL = 8'd7;
	localparam logic [7:0] P_DIV = 8'd8;
	localparam logic [7:0] P_AND = 8'd9;
	localparam logic [7:0] P_OR = 8'd10;
	localparam logic [7:0] P_XOR = 8'd11;
	localparam logic [7:0] P_NOT = 8'd12;
	localparam logic [7:0] P_ZEQ = 8'd13;
	localparam logic [7:0] P_ZGT = 8'd14;
	localparam logic [7:0] P_ZLT = 8'd15;
	localparam logic [7:0] P_NEG = 8'd16;
	localparam logic [7:0] P_INC = 8'd17;
	localparam logic [7:0] P_DEC = 8'd18;
	localparam logic [7:0] P_SHL = 8'd19;
	localparam logic [7:0] P_SHR = 8'd20;
	localparam logic [7:0] P_DUP = 8'd21;
	localparam logic [7:0] P_DROP = 8'd22;
	localparam logic [7:0] P_SWAP = 8'd23;
	localparam logic [7:0] P_ROT = 8'd24;
	localparam logic [7:0] P_OVER = 8'd25;
	localparam logic [7:0] P_RET = 8'd26;
	localparam logic [7:0] P_RFROM = 8'd27;
	localparam logic [7:0] P_TOR = 8'd28;
	localparam logic [7:0] P_HWIO = 8'd29;

	localparam logic [31:0] LIT_SIGN = 32'h4000_0000;

	typedef enum logic [4:0] {
		ST_IDLE, ST_FETCH, ST_DECODE, ST_RD_A, ST_RD_B, ST_RD_C, ST_RD_D,
		ST_EXEC, ST_DIV, ST_WR_A, ST_WR_B, ST_WR_C, ST_HOST_RD, ST_RST_RD,
		ST_DONE
	} state_t;

	// one command word passed from front to back
	typedef struct packed {
		logic [1:0]  action;
		logic [19:0] host_address;
		logic [31:0] host_data;
		logic [7:0]  key_code;
	} cmd_t;

endpackage

/* rtl/core/fscs_ram.sv */
module fscs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/core/fscs_front.sv */
module fscs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  fscs_pkg::cmd_t      cmd_in,
	input  logic                take,
	output logic                avail,
	output fscs_pkg::cmd_t      cmd_out
);
	// two-entry queue of command words
	fscs_pkg::cmd_t buf_q [2];
	logic           rd_q, wr_q;
	logic [1:0]     cnt_q;
	logic           do_push, do_pop;

	assign full    = cnt_q == 2'd2;
	assign avail   = cnt_q != 2'd0;
	assign cmd_out = buf_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = take && avail;

	// store payload
	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_q] <= cmd_in;
		end
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |-> cnt_q != 2'd0)
		else $error("pop on empty");
	a_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> cnt_q == $past(cnt_q) - 2'd1)
		else $error("count mismatch");
endmodule

/* rtl/core/fscs_div.sv */
module fscs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] quotient
);
	logic [31:0] q_q, r_q, d_q;
	logic [5:0]  n_q;
	logic [32:0] trial;

	assign busy     = n_q != 6'd0;
	assign quotient = q_q;
	assign trial    = {r_q, q_q[31]} - {1'b0, d_q};

	// restoring division, one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 6'd0;
		end else if (start) begin
			n_q <= 6'd32;
		end else if (busy) begin
			n_q <= n_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= 32'd0;
			d_q <= divisor;
		end else if (busy) begin
			if (!trial[32]) begin
				r_q <= trial[31:0];
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= {r_q[30:0], q_q[31]};
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end
endmodule

/* rtl/core/fscs_back.sv */
module fscs_back #(
	parameter int MEMORY_WORDS = 262144
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                avail,
	output logic                take,
	input  fscs_pkg::cmd_t      cmd,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_idx,
	input  logic [20:0]         cfg_data,
	output logic                res_valid,
	input  logic                res_take,
	output logic [7:0]          frame_mark,
	output logic [31:0]         read_word,
	output logic [19:0]         program_counter,
	output logic [1:0]          screen_command,
	output logic [31:0]         screen_value,
	output logic                key_taken,
	output logic                fault
);
	localparam int AW = $clog2(MEMORY_WORDS);

	// configuration
	logic [20:0] dsr_q, rsr_q;
	logic [19:0] ipf_q;
	logic [7:0]  frv_q;

	// architectural state
	logic [19:0] pc_q;
	logic [20:0] dsp_q, rsp_q;
	logic [19:0] icnt_q;
	logic        halt_q;

	fscs_pkg::state_t st_q, st_d;
	fscs_pkg::cmd_t   cur_q;
	logic [31:0] ins_q, t_q, n_q, x_q;
	logic [31:0] w1_q, w2_q, w3_q;
	logic [AW-1:0] a1_q, a2_q, a3_q;
	logic        e1_q, e2_q, e3_q;
	logic [19:0] npc_q;
	logic [20:0] ndsp_q, nrsp_q;
	logic        cnt_q;
	logic        bad_q;
	logic [1:0]  scmd_q;
	logic [31:0] sval_q, rword_q;
	logic        kt_q;
	logic [7:0]  fm_q;
	logic        out_full_q;

	// memory port
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wdata, rdata;

	fscs_ram #(.WIDTH(32), .DEPTH(MEMORY_WORDS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic        div_start, div_busy;
	logic [31:0] div_q;
	fscs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(n_q),
		.divisor(t_q), .busy(div_busy), .quotient(div_q)
	);

	function automatic logic [AW-1:0] widx(input logic [20:0] b, input logic [1:0] ex);
		logic [18:0] w;
		w = b[20:2] + {17'd0, ex};
		return w[AW-1:0];
	endfunction

	logic [3:0]  kind;
	logic [7:0]  code;
	logic [19:0] pc4;
	logic [19:0] tgt;
	logic [31:0] lit;
	assign kind = ins_q[31:28];
	assign code = ins_q[7:0];
	assign pc4  = pc_q + 20'd4;
	assign tgt  = pc4 + ins_q[19:0];
	assign lit  = {ins_q[30], ins_q[30:0]};

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			fscs_pkg::ST_IDLE: begin
				if (avail && !out_full_q) begin
					case (fscs_pkg::action_t'(cmd.action))
						fscs_pkg::ACT_READ:  st_d = fscs_pkg::ST_HOST_RD;
						fscs_pkg::ACT_WRITE: st_d = fscs_pkg::ST_DONE;
						fscs_pkg::ACT_RESET: st_d = fscs_pkg::ST_RST_RD;
						default: st_d = halt_q ? fscs_pkg::ST_DONE : fscs_pkg::ST_FETCH;
					endcase
				end
			end
			fscs_pkg::ST_FETCH:  st_d = fscs_pkg::ST_DECODE;
			fscs_pkg::ST_DECODE: st_d = fscs_pkg::ST_RD_A;
			fscs_pkg::ST_RD_A:   st_d = fscs_pkg::ST_RD_B;
			fscs_pkg::ST_RD_B:   st_d = fscs_pkg::ST_RD_C;
			fscs_pkg::ST_RD_C:   st_d = fscs_pkg::ST_RD_D;
			fscs_pkg::ST_RD_D:   st_d = fscs_pkg::ST_EXEC;
			fscs_pkg::ST_EXEC:   st_d = (kind == fscs_pkg::KIND_PRIM && code == fscs_pkg::P_DIV)
				? fscs_pkg::ST_DIV : fscs_pkg::ST_WR_A;
			fscs_pkg::ST_DIV:    st_d = div_busy ? fscs_pkg::ST_DIV : fscs_pkg::ST_WR_A;
			fscs_pkg::ST_WR_A:   st_d = fscs_pkg::ST_WR_B;
			fscs_pkg::ST_WR_B:   st_d = fscs_pkg::ST_WR_C;
			fscs_pkg::ST_WR_C:   st_d = fscs_pkg::ST_DONE;
			fscs_pkg::ST_HOST_RD: st_d = fscs_pkg::ST_DONE;
			fscs_pkg::ST_RST_RD: st_d = fscs_pkg::ST_DONE;
			fscs_pkg::ST_DONE:   st_d = fscs_pkg::ST_IDLE;
			default:             st_d = fscs_pkg::ST_IDLE;
		endcase
	end

	// read address per state: fetch, T, N, third, indirect or return top
	always_comb begin
		raddr = widx(dsp_q, 2'd0);
		case (st_q)
			fscs_pkg::ST_IDLE:   raddr = (cmd.action == fscs_pkg::ACT_READ)
				? widx({1'b0, cmd.host_address}, 2'd0)
				: (cmd.action == fscs_pkg::ACT_RESET ? widx(21'd8, 2'd0)
				: widx({1'b0, pc_q}, 2'd0));
			fscs_pkg::ST_DECODE: raddr = widx(dsp_q, 2'd0);
			fscs_pkg::ST_RD_A:   raddr = widx(dsp_q, 2'd1);
			fscs_pkg::ST_RD_B:   raddr = widx(dsp_q, 2'd2);
			fscs_pkg::ST_RD_C:   raddr = (code == fscs_pkg::P_RET || code == fscs_pkg::P_RFROM)
				? widx(rsp_q, 2'd0)
				: ((code == fscs_pkg::P_CFETCH) ? widx({t_q[20:2], 2'b00}, 2'd0)
				: ((code == fscs_pkg::P_CSTORE || code == fscs_pkg::P_PSTORE
					|| code == fscs_pkg::P_FETCH) ? widx(t_q[20:0], 2'd0)
				: widx(rsp_q, 2'd0)));
			default: ;
		endcase
	end

	// execute: compute all effects as up to three writes
	logic [31:0] ex_t, bm;
	logic [4:0]  sh;
	logic [19:0] ex_pc;
	logic [20:0] ex_dsp, ex_rsp;
	logic        ex_bad, ex_cnt;
	logic [AW-1:0] ea1, ea2, ea3;
	logic [31:0] ew1, ew2, ew3;
	logic        ee1, ee2, ee3;
	logic [1:0]  ex_scmd;
	logic [31:0] ex_sval;
	logic        ex_kt;
	always_comb begin
		ex_pc = pc4; ex_dsp = dsp_q; ex_rsp = rsp_q; ex_bad = 1'b0; ex_cnt = 1'b1;
		ea1 = '0; ea2 = '0; ea3 = '0; ew1 = '0; ew2 = '0; ew3 = '0;
		ee1 = 1'b0; ee2 = 1'b0; ee3 = 1'b0;
		ex_scmd = 2'd0; ex_sval = '0; ex_kt = 1'b0;
		sh = {t_q[1:0], 3'b000};
		bm = 32'hFF << sh;
		ex_t = '0;
		case (kind)
			fscs_pkg::KIND_CALL: begin
				ex_rsp = rsp_q - 21'd4;
				ee1 = 1'b1; ea1 = widx(ex_rsp, 2'd0); ew1 = {12'd0, pc4};
				ex_pc = {tgt[19:2], 2'b00};
			end
			fscs_pkg::KIND_BRANCH: ex_pc = {tgt[19:2], 2'b00};
			fscs_pkg::KIND_BZERO: begin
				ex_dsp = dsp_q + 21'd4;
				if (t_q == 32'd0) ex_pc = {tgt[19:2], 2'b00};
			end
			fscs_pkg::KIND_PRIM: begin
				case (code)
					fscs_pkg::P_FETCH: begin
						if (t_q[1:0] != 2'd0) ex_bad = 1'b1;
						else begin ee1 = 1'b1; ea1 = widx(dsp_q, 2'd0); ew1 = x_q; end
					end
					fscs_pkg::P_STORE, fscs_pkg::P_PSTORE: begin
						if (t_q[1:0] != 2'd0) ex_bad = 1'b1;
						else begin
							ex_dsp = dsp_q + 21'd8;
							ee1 = 1'b1; ea1 = widx(t_q[20:0], 2'd0);
							ew1 = (code == fscs_pkg::P_STORE) ? n_q : x_q + n_q;
						end
					end
					fscs_pkg::P_CFETCH: begin
						ee1 = 1'b1; ea1 = widx(dsp_q, 2'd0); ew1 = (x_q >> sh) & 32'hFF;
					end
					fscs_pkg::P_CSTORE: begin
						ex_dsp = dsp_q + 21'd8;
						ee1 = 1'b1; ea1 = widx({t_q[20:2], 2'b00}, 2'd0);
						ew1 = (x_q & ~bm) | ({24'd0, n_q[7:0]} << sh);
					end
					fscs_pkg::P_ADD, fscs_pkg::P_SUB, fscs_pkg::P_MUL, fscs_pkg::P_DIV,
					fscs_pkg::P_AND, fscs_pkg::P_OR, fscs_pkg::P_XOR: begin
						ex_dsp = dsp_q + 21'd4;
						ee1 = 1'b1; ea1 = widx(ex_dsp, 2'd0);
						case (code)
							fscs_pkg::P_ADD: ew1 = n_q + t_q;
							fscs_pkg::P_SUB: ew1 = n_q - t_q;
							fscs_pkg::P_MUL: ew1 = x_q;
							fscs_pkg::P_AND: ew1 = n_q & t_q;
							fscs_pkg::P_OR:  ew1 = n_q | t_q;
							fscs_pkg::P_XOR: ew1 = n_q ^ t_q;
							default:         ew1 = (t_q == 32'd0) ? 32'd0 : div_q;
						endcase
					end
					fscs_pkg::P_NOT, fscs_pkg::P_ZEQ, fscs_pkg::P_ZGT, fscs_pkg::P_ZLT,
					fscs_pkg::P_NEG, fscs_pkg::P_INC, fscs_pkg::P_DEC, fscs_pkg::P_SHL,
					fscs_pkg::P_SHR: begin
						case (code)
							fscs_pkg::P_NOT: ex_t = ~t_q;
							fscs_pkg::P_ZEQ: ex_t = {32{t_q == 32'd0}};
							fscs_pkg::P_ZGT: ex_t = {32{!t_q[31] && t_q != 32'd0}};
							fscs_pkg::P_ZLT: ex_t = {32{t_q[31]}};
							fscs_pkg::P_NEG: ex_t = 32'd0 - t_q;
							fscs_pkg::P_INC: ex_t = t_q + 32'd1;
							fscs_pkg::P_DEC: ex_t = t_q - 32'd1;
							fscs_pkg::P_SHL: ex_t = {t_q[30:0], 1'b0};
							default:         ex_t = {1'b0, t_q[31:1]};
						endcase
						ee1 = 1'b1; ea1 = widx(dsp_q, 2'd0); ew1 = ex_t;
					end
					fscs_pkg::P_DUP, fscs_pkg::P_OVER: begin
						ex_dsp = dsp_q - 21'd4;
						ee1 = 1'b1; ea1 = widx(ex_dsp, 2'd0);
						ew1 = (code == fscs_pkg::P_DUP) ? t_q : n_q;
					end
					fscs_pkg::P_DROP: ex_dsp = dsp_q + 21'd4;
					fscs_pkg::P_SWAP: begin
						ee1 = 1'b1; ea1 = widx(dsp_q, 2'd1); ew1 = t_q;
						ee2 = 1'b1; ea2 = widx(dsp_q, 2'd0); ew2 = n_q;
					end
					fscs_pkg::P_ROT: begin
						ee1 = 1'b1; ea1 = widx(dsp_q, 2'd2); ew1 = n_q;
						ee2 = 1'b1; ea2 = widx(dsp_q, 2'd1); ew2 = t_q;
						ee3 = 1'b1; ea3 = widx(dsp_q, 2'd0); ew3 = x_q;
					end
					fscs_pkg::P_RET: begin
						ex_rsp = rsp_q + 21'd4; ex_pc = {x_q[19:2], 2'b00};
					end
					fscs_pkg::P_RFROM: begin
						ex_rsp = rsp_q + 21'd4; ex_dsp = dsp_q - 21'd4;
						ee1 = 1'b1; ea1 = widx(ex_dsp, 2'd0); ew1 = x_q;
					end
					fscs_pkg::P_TOR: begin
						ex_dsp = dsp_q + 21'd4; ex_rsp = rsp_q - 21'd4;
						ee1 = 1'b1; ea1 = widx(ex_rsp, 2'd0); ew1 = t_q;
					end
					fscs_pkg::P_HWIO: begin
						if (t_q == 32'd0) begin
							ex_kt = 1'b1;
							ee1 = 1'b1; ea1 = widx(dsp_q, 2'd0); ew1 = {24'd0, cur_q.key_code};
						end else if (t_q == 32'd1 || t_q == 32'd2) begin
							ex_dsp = dsp_q + 21'd8; ex_scmd = t_q[1:0]; ex_sval = n_q;
						end else begin
							ex_dsp = dsp_q + 21'd4;
						end
					end
					default: ;
				endcase
			end
			default: begin
				ex_dsp = dsp_q - 21'd4;
				ee1 = 1'b1; ea1 = widx(ex_dsp, 2'd0); ew1 = lit;
			end
		endcase
		if (ex_bad) begin
			ex_cnt = 1'b0; ex_pc = pc_q; ex_dsp = dsp_q; ex_rsp = rsp_q;
		end
	end

	// write port mux
	always_comb begin
		we = 1'b0; waddr = a1_q; wdata = w1_q;
		case (st_q)
			fscs_pkg::ST_IDLE: begin
				we = avail && !out_full_q && cmd.action == fscs_pkg::ACT_WRITE;
				waddr = widx({1'b0, cmd.host_address}, 2'd0); wdata = cmd.host_data;
			end
			fscs_pkg::ST_WR_A: begin we = e1_q; waddr = a1_q; wdata = w1_q; end
			fscs_pkg::ST_WR_B: begin we = e2_q; waddr = a2_q; wdata = w2_q; end
			fscs_pkg::ST_WR_C: begin we = e3_q; waddr = a3_q; wdata = w3_q; end
			fscs_pkg::ST_RST_RD: begin
				we = 1'b1; waddr = widx(dsr_q - 21'd4, 2'd0); wdata = 32'd0;
			end
			default: ;
		endcase
	end

	assign take      = st_q == fscs_pkg::ST_IDLE && avail && !out_full_q;
	assign div_start = st_q == fscs_pkg::ST_EXEC && kind == fscs_pkg::KIND_PRIM
		&& code == fscs_pkg::P_DIV;

	logic [19:0] cnt_inc;
	assign cnt_inc = icnt_q + 20'd1;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= fscs_pkg::ST_IDLE;
			dsr_q <= 21'd1040384; rsr_q <= 21'd1048576;
			ipf_q <= 20'd1000000; frv_q <= 8'd60;
			pc_q <= '0; dsp_q <= 21'd1040384; rsp_q <= 21'd1048576;
			icnt_q <= '0; halt_q <= 1'b0; out_full_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				case (cfg_idx)
					fscs_pkg::CFG_DSP_RESET: dsr_q <= cfg_data;
					fscs_pkg::CFG_RSP_RESET: rsr_q <= cfg_data;
					fscs_pkg::CFG_IPF:       ipf_q <= cfg_data[19:0];
					default:                 frv_q <= cfg_data[7:0];
				endcase
			end
			if (st_q == fscs_pkg::ST_RST_RD) begin
				pc_q <= {rdata[19:2], 2'b00};
				dsp_q <= dsr_q - 21'd4; rsp_q <= rsr_q;
				icnt_q <= '0; halt_q <= 1'b0;
			end
			if (st_q == fscs_pkg::ST_WR_C) begin
				pc_q <= npc_q; dsp_q <= ndsp_q; rsp_q <= nrsp_q;
				if (bad_q) halt_q <= 1'b1;
				if (cnt_q) begin
					icnt_q <= (cnt_inc >= ipf_q) ? cnt_inc - ipf_q : cnt_inc;
				end
			end
			if (st_q == fscs_pkg::ST_DONE) out_full_q <= 1'b1;
			else if (res_take) out_full_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			fscs_pkg::ST_IDLE: begin
				if (take) begin
					cur_q <= cmd;
					scmd_q <= 2'd0; sval_q <= '0; kt_q <= 1'b0; fm_q <= '0; rword_q <= '0;
				end
			end
			fscs_pkg::ST_FETCH:  ins_q <= rdata;
			fscs_pkg::ST_RD_A:   t_q <= rdata;
			fscs_pkg::ST_RD_B:   n_q <= rdata;
			fscs_pkg::ST_RD_C:   x_q <= rdata;
			fscs_pkg::ST_RD_D: begin
				if (code == fscs_pkg::P_MUL) x_q <= n_q * t_q;
				else if (code != fscs_pkg::P_ROT) x_q <= rdata;
			end
			fscs_pkg::ST_EXEC, fscs_pkg::ST_DIV: begin
				a1_q <= ea1; a2_q <= ea2; a3_q <= ea3;
				w1_q <= ew1; w2_q <= ew2; w3_q <= ew3;
				e1_q <= ee1; e2_q <= ee2; e3_q <= ee3;
				npc_q <= ex_pc; ndsp_q <= ex_dsp; nrsp_q <= ex_rsp;
				bad_q <= ex_bad; cnt_q <= ex_cnt;
				scmd_q <= ex_scmd; sval_q <= ex_sval; kt_q <= ex_kt;
			end
			fscs_pkg::ST_WR_C: begin
				if (cnt_q && cnt_inc >= ipf_q) fm_q <= frv_q;
			end
			fscs_pkg::ST_HOST_RD: rword_q <= rdata;
			default: ;
		endcase
	end

	assign res_valid       = out_full_q;
	assign frame_mark      = fm_q;
	assign read_word       = rword_q;
	assign program_counter = pc_q;
	assign screen_command  = scmd_q;
	assign screen_value    = sval_q;
	assign key_taken       = kt_q;
	assign fault           = halt_q;

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> st_q == fscs_pkg::ST_IDLE && !out_full_q)
		else $error("command taken while busy");
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> st_q == fscs_pkg::ST_DIV)
		else $error("divide not tracked");
	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(halt_q) |-> $past(st_q) == fscs_pkg::ST_WR_C)
		else $error("halt outside commit");
endmodule

/* rtl/core/forth_stack_cpu_step_top.sv */
// Forth stack processor step engine.
// Input channel: push/full carries one command word (action, host_address,
// host_data, key_code). Action execute runs one instruction, read returns a
// memory word, write stores one, reset restarts the processor.
// Result channel: empty/pop; one result word per command, holding frame_mark,
// read_word, program_counter, screen_command, screen_value, key_taken, fault.
// Config: cfg_we/cfg_index/cfg_data write a register; write only while idle.
// An instruction runs through the single-port memory sequence (fetch, three
// stack reads, indirect read, execute, three writes), and divide waits on
// the divider (one quotient bit per cycle). One instruction is in flight
// at a time.
// A two-word input queue accepts commands while the core works.
// Reset: arst_n clears the queue, processor state and registers to defaults;
// memory contents are undefined until written.
// If the receiver stalls, the result is held and the next command waits.
module forth_stack_cpu_step_top #(
	parameter int MEMORY_WORDS = 262144
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  action,
	input  logic [19:0] host_address,
	input  logic [31:0] host_data,
	input  logic [7:0]  key_code,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [20:0] cfg_data,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  frame_mark,
	output logic [31:0] read_word,
	output logic [19:0] program_counter,
	output logic [1:0]  screen_command,
	output logic [31:0] screen_value,
	output logic        key_taken,
	output logic        fault
);
	fscs_pkg::cmd_t cin, cq;
	logic avail, take, res_valid;

	assign cin = '{action: action, host_address: host_address,
		host_data: host_data, key_code: key_code};

	fscs_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd_in(cin),
		.take(take), .avail(avail), .cmd_out(cq)
	);

	fscs_back #(.MEMORY_WORDS(MEMORY_WORDS)) u_back (
		.clk(clk), .arst_n(arst_n), .avail(avail), .take(take), .cmd(cq),
		.cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
		.res_valid(res_valid), .res_take(pop && !empty),
		.frame_mark(frame_mark), .read_word(read_word),
		.program_counter(program_counter), .screen_command(screen_command),
		.screen_value(screen_value), .key_taken(key_taken), .fault(fault)
	);

	assign empty = !res_valid;
endmodule

/* tb/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fscs_pkg::*;

	localparam int MEMW     = 262144;
	localparam int LIMIT    = 5000;
	localparam int SETTLE   = 60;
	localparam int PER_LOOP = 375;

	typedef struct {
		action_t     act;
		logic [19:0] addr;
		logic [31:0] data;
		logic [7:0]  key;
	} cmd_word_t;

	typedef struct {
		logic [7:0]  frame;
		logic [31:0] rword;
		logic [19:0] pc;
		logic [1:0]  scmd;
		logic [31:0] sval;
		logic        ktaken;
		logic        fault;
	} step_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  action = ACT_EXEC;
	logic [19:0] host_address = '0;
	logic [31:0] host_data = '0;
	logic [7:0]  key_code = '0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_DSP_RESET;
	logic [20:0] cfg_data = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  frame_mark;
	logic [31:0] read_word;
	logic [19:0] program_counter;
	logic [1:0]  screen_command;
	logic [31:0] screen_value;
	logic        key_taken;
	logic        fault;

	forth_stack_cpu_step_top i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .action(action),
		.host_address(host_address), .host_data(host_data), .key_code(key_code),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.empty(empty), .pop(pop), .frame_mark(frame_mark), .read_word(read_word),
		.program_counter(program_counter), .screen_command(screen_command),
		.screen_value(screen_value), .key_taken(key_taken), .fault(fault)
	);

	// processor shadow: memory, registers and settings
	logic [31:0] cpu_mem [MEMW];
	bit          cpu_known [MEMW];
	int unsigned known_list [$];
	logic [19:0] cpu_pc;
	logic [20:0] cpu_dsp, cpu_rsp;
	logic [19:0] cpu_icnt;
	bit          cpu_halt;
	logic [20:0] set_dsr, set_rsr;
	logic [19:0] set_ipf;
	logic [7:0]  set_frv;

	cmd_word_t  pend_cmds [$];
	step_word_t pend_steps [$];
	step_word_t step_q [$];
	step_word_t cur_step;

	bit steady = 1'b0;
	int errors = 0;
	int n_checked = 0;
	int n_cmds = 0;
	int n_exec = 0;
	int n_halts = 0;
	int n_frames = 0;
	int stall_cnt = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned widx(logic [31:0] a, int unsigned e);
		return ((a >> 2) + e) % MEMW;
	endfunction

	function automatic void mput(int unsigned i, logic [31:0] v);
		if (!cpu_known[i]) begin
			cpu_known[i] = 1'b1;
			known_list.push_back(i);
		end
		cpu_mem[i] = v;
	endfunction

	function automatic void push_d(logic [31:0] v);
		cpu_dsp = cpu_dsp - 21'd4;
		mput(widx(cpu_dsp, 0), v);
	endfunction

	function automatic logic [31:0] pop_d();
		logic [31:0] v;
		v = cpu_mem[widx(cpu_dsp, 0)];
		cpu_dsp = cpu_dsp + 21'd4;
		return v;
	endfunction

	function automatic void push_r(logic [31:0] v);
		cpu_rsp = cpu_rsp - 21'd4;
		mput(widx(cpu_rsp, 0), v);
	endfunction

	function automatic logic [31:0] pop_r();
		logic [31:0] v;
		v = cpu_mem[widx(cpu_rsp, 0)];
		cpu_rsp = cpu_rsp + 21'd4;
		return v;
	endfunction

	// run one primitive; return 0 on a misaligned word access
	function automatic bit run_prim(logic [7:0] code, logic [7:0] key, ref step_word_t r);
		int unsigned ti, i, b, c;
		logic [31:0] tv, x, y;
		int sh;
		ti = widx(cpu_dsp, 0);
		tv = cpu_mem[ti];
		case (code)
			P_FETCH: begin
				if (tv[1:0] != 2'd0) return 1'b0;
				mput(ti, cpu_mem[widx(tv, 0)]);
			end
			P_STORE, P_PSTORE: begin
				if (tv[1:0] != 2'd0) return 1'b0;
				x = pop_d();
				y = pop_d();
				i = widx(x, 0);
				mput(i, (code == P_STORE) ? y : cpu_mem[i] + y);
			end
			P_CFETCH: begin
				sh = tv[1:0] * 8;
				mput(ti, (cpu_mem[widx(tv, 0)] >> sh) & 32'hFF);
			end
			P_CSTORE: begin
				x = pop_d();
				y = pop_d();
				i = widx(x, 0);
				sh = x[1:0] * 8;
				mput(i, (cpu_mem[i] & ~(32'hFF << sh)) | ((y & 32'hFF) << sh));
			end
			P_ADD, P_SUB, P_MUL, P_DIV, P_AND, P_OR, P_XOR: begin
				x = pop_d();
				i = widx(cpu_dsp, 0);
				y = cpu_mem[i];
				case (code)
					P_ADD: y = y + x;
					P_SUB: y = y - x;
					P_MUL: y = y * x;
					P_DIV: y = (x != 0) ? y / x : 32'd0;
					P_AND: y = y & x;
					P_OR:  y = y | x;
					default: y = y ^ x;
				endcase
				mput(i, y);
			end
			P_NOT: mput(ti, ~tv);
			P_ZEQ: mput(ti, (tv == 0) ? 32'hFFFF_FFFF : 32'd0);
			P_ZGT: mput(ti, (!tv[31] && tv != 0) ? 32'hFFFF_FFFF : 32'd0);
			P_ZLT: mput(ti, tv[31] ? 32'hFFFF_FFFF : 32'd0);
			P_NEG: mput(ti, 32'd0 - tv);
			P_INC: mput(ti, tv + 32'd1);
			P_DEC: mput(ti, tv - 32'd1);
			P_SHL: mput(ti, tv << 1);
			P_SHR: mput(ti, tv >> 1);
			P_DUP: push_d(tv);
			P_DROP: x = pop_d();
			P_SWAP: begin
				b = widx(cpu_dsp, 1);
				mput(ti, cpu_mem[b]);
				mput(b, tv);
			end
			P_ROT: begin
				b = widx(cpu_dsp, 1);
				c = widx(cpu_dsp, 2);
				x = cpu_mem[c];
				mput(c, cpu_mem[b]);
				mput(b, cpu_mem[ti]);
				mput(ti, x);
			end
			P_OVER: push_d(cpu_mem[widx(cpu_dsp, 1)]);
			P_RET: cpu_pc = pop_r() & 32'hFFFFC;
			P_RFROM: push_d(pop_r());
			P_TOR: push_r(pop_d());
			P_HWIO: begin
				x = pop_d();
				if (x == 0) begin
					push_d({24'd0, key});
					r.ktaken = 1'b1;
				end else if (x == 1 || x == 2) begin
					r.sval = pop_d();
					r.scmd = x[1:0];
				end
			end
			default: ;
		endcase
		return 1'b1;
	endfunction

	// advance the shadow by one command word and return the result word
	function automatic step_word_t cpu_step(cmd_word_t w);
		step_word_t r;
		logic [19:0] old_pc;
		logic [31:0] ins, off, lit;
		bit ok;
		r = '{default: '0};
		case (w.act)
			ACT_READ: r.rword = cpu_mem[widx(w.addr, 0)];
			ACT_WRITE: mput(widx(w.addr, 0), w.data);
			ACT_RESET: begin
				cpu_pc = cpu_mem[2] & 32'hFFFFC;
				cpu_dsp = set_dsr;
				cpu_rsp = set_rsr;
				cpu_icnt = '0;
				cpu_halt = 1'b0;
				push_d(32'd0);
			end
			default: if (!cpu_halt) begin
				ok = 1'b1;
				old_pc = cpu_pc;
				ins = cpu_mem[widx(cpu_pc, 0)];
				off = ins & 32'h0FFF_FFFF;
				cpu_pc = (cpu_pc + 20'd4) & 20'hFFFFC;
				case (ins[31:28])
					KIND_CALL: begin
						push_r({12'd0, cpu_pc});
						cpu_pc = (cpu_pc + off) & 32'hFFFFC;
					end
					KIND_BRANCH: cpu_pc = (cpu_pc + off) & 32'hFFFFC;
					KIND_BZERO: if (pop_d() == 0) cpu_pc = (cpu_pc + off) & 32'hFFFFC;
					KIND_PRIM: ok = run_prim(ins[7:0], w.key, r);
					default: begin
						lit = ins & 32'h7FFF_FFFF;
						if ((lit & LIT_SIGN) != 0) lit[31] = 1'b1;
						push_d(lit);
					end
				endcase
				if (!ok) begin
					cpu_pc = old_pc;
					cpu_halt = 1'b1;
				end else begin
					cpu_icnt = cpu_icnt + 20'd1;
					if (cpu_icnt >= set_ipf) begin
						cpu_icnt = cpu_icnt - set_ipf;
						r.frame = set_frv;
					end
				end
			end
		endcase
		r.pc = cpu_pc;
		r.fault = cpu_halt;
		return r;
	endfunction

	// queue one command word along with its predicted result
	task automatic send(action_t act, logic [19:0] addr, logic [31:0] data);
		cmd_word_t w;
		w.act = act;
		w.addr = addr;
		w.data = data;
		w.key = 8'($urandom);
		if (act == ACT_EXEC) n_exec++;
		if (act == ACT_EXEC && !cpu_halt && w.key == 0) w.key = 8'($urandom);
		pend_steps.push_back(cpu_step(w));
		pend_cmds.push_back(w);
		n_cmds++;
	endtask

	task automatic host_put(int unsigned i, logic [31:0] v);
		send(ACT_WRITE, 20'((i << 2) | $urandom_range(0, 3)), v);
	endtask

	task automatic fill(int unsigned i);
		if (!cpu_known[i]) host_put(i, $urandom);
	endtask

	// place an instruction at the PC, make its operands readable, run it
	task automatic run_ins(bit fresh, logic [31:0] ins, bit set_top, logic [31:0] top);
		if (!cpu_halt) begin
			if (fresh || !cpu_known[widx(cpu_pc, 0)]) host_put(widx(cpu_pc, 0), ins);
			fill(widx(cpu_dsp, 0));
			fill(widx(cpu_dsp, 1));
			fill(widx(cpu_dsp, 2));
			fill(widx(cpu_rsp, 0));
			if (set_top) host_put(widx(cpu_dsp, 0), top);
			fill(widx(cpu_mem[widx(cpu_dsp, 0)], 0));
		end
		send(ACT_EXEC, 20'($urandom), $urandom);
	endtask

	task automatic restart();
		fill(2);
		send(ACT_RESET, 20'($urandom), $urandom);
	endtask

	function automatic logic [31:0] offset();
		if ($urandom_range(0, 9) == 0) return $urandom & 32'h0FFF_FFFF;
		return $urandom_range(0, 15) * 4;
	endfunction

	// one random instruction, mostly with sensible operands
	task automatic rand_exec();
		logic [31:0] ins, top;
		logic [7:0] code;
		bit set_top;
		int r;
		r = $urandom_range(0, 99);
		ins = $urandom;
		code = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(30, 255)) :
			8'($urandom_range(0, 29));
		if (r < 50) ins = {KIND_PRIM, ins[27:8], code};
		else if (r < 62) begin
			while (ins[31:28] >= KIND_CALL && ins[31:28] != 4'hB && ins[31:28] != 4'hC &&
				ins[31:28] != 4'hD && ins[31:28] != 4'hE) ins[31:28] = 4'($urandom);
		end else if (r < 72) ins = {KIND_CALL, offset() & 32'h0FFF_FFFF};
		else if (r < 82) ins = {KIND_BRANCH, offset() & 32'h0FFF_FFFF};
		else if (r < 92) ins = {KIND_BZERO, offset() & 32'h0FFF_FFFF};
		else ins = {KIND_PRIM, ins[27:8], P_HWIO};
		set_top = 1'b0;
		top = $urandom;
		if (ins[31:28] == KIND_PRIM) begin
			case (ins[7:0])
				P_FETCH, P_STORE, P_PSTORE: begin
					set_top = ($urandom_range(0, 9) < 7);
					top[1:0] = 2'd0;
				end
				P_HWIO: begin
					set_top = ($urandom_range(0, 9) < 7);
					top = $urandom_range(0, 3);
				end
				P_DIV: begin
					set_top = ($urandom_range(0, 9) < 2);
					top = 0;
				end
				default: ;
			endcase
		end else if (ins[31:28] == KIND_BZERO) begin
			set_top = $urandom_range(0, 1);
			top = 0;
		end
		run_ins($urandom_range(0, 2) == 0, ins, set_top, top);
	endtask

	task automatic rand_loop(int count);
		int start, r;
		start = n_cmds;
		while (n_cmds - start < count) begin
			r = $urandom_range(0, 99);
			if (cpu_halt && r < 40) restart();
			else if (r < 78) rand_exec();
			else if (r < 86 && known_list.size() > 0)
				send(ACT_READ, 20'((known_list[$urandom_range(0, known_list.size() - 1)] << 2) |
					$urandom_range(0, 3)), $urandom);
			else if (r < 96) send(ACT_WRITE, 20'($urandom), $urandom);
			else restart();
		end
	endtask

	task automatic wait_quiet();
		do @(posedge clk); while (pend_cmds.size() != 0 || push || step_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_reg(logic [1:0] idx, logic [20:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			CFG_DSP_RESET: set_dsr = v;
			CFG_RSP_RESET: set_rsr = v;
			CFG_IPF: set_ipf = v[19:0];
			default: set_frv = v[7:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic new_setting(logic [20:0] dsr, logic [20:0] rsr, logic [19:0] ipf,
		logic [7:0] frv);
		wait_quiet();
		set_reg(CFG_DSP_RESET, dsr);
		set_reg(CFG_RSP_RESET, rsr);
		set_reg(CFG_IPF, {1'b0, ipf});
		set_reg(CFG_FRAME, {13'd0, frv});
		restart();
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h, want %h (result %0d)", what, got, want, n_checked);
		errors++;
	endtask

	// drive command words from the pending queue
	always @(posedge clk) begin : drive
		cmd_word_t w;
		if (arst_n) begin
			if (push && !full) step_q.push_back(cur_step);
			if (!push || !full) begin
				if (pend_cmds.size() != 0 && (steady || $urandom_range(0, 99) >= 26)) begin
					w = pend_cmds.pop_front();
					cur_step <= pend_steps.pop_front();
					push <= 1'b1;
					action <= w.act;
					host_address <= w.addr;
					host_data <= w.data;
					key_code <= w.key;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// check each result word against the oldest prediction
	always @(posedge clk) begin : watch
		step_word_t e;
		if (arst_n) begin
			if (pop && !empty) begin
				if (step_q.size() == 0) begin
					$display("unexpected result word, pc %h", program_counter);
					errors++;
				end else begin
					e = step_q.pop_front();
					if (frame_mark != e.frame) report("frame_mark", frame_mark, e.frame);
					if (read_word != e.rword) report("read_word", read_word, e.rword);
					if (program_counter != e.pc) report("program_counter", program_counter, e.pc);
					if (screen_command != e.scmd) report("screen_command", screen_command, e.scmd);
					if (screen_value != e.sval) report("screen_value", screen_value, e.sval);
					if (key_taken != e.ktaken) report("key_taken", key_taken, e.ktaken);
					if (fault != e.fault) report("fault", fault, e.fault);
					if (e.fault) n_halts++;
					if (e.frame != 0) n_frames++;
				end
				n_checked++;
			end
			pop <= steady || ($urandom_range(0, 99) >= 26);
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) stall_cnt <= 0;
		else stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= LIMIT) begin
			$display("[forth_stack_cpu_step_top] ERROR");
			$finish;
		end
	end

	initial begin
		cpu_pc = '0;
		set_dsr = 21'd1040384;
		set_rsr = 21'd1048576;
		set_ipf = 20'd1000000;
		set_frv = 8'd60;
		cpu_dsp = set_dsr;
		cpu_rsp = set_rsr;
		cpu_icnt = '0;
		cpu_halt = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: literal extremes, divide by zero, I/O commands, halt and restart
		run_ins(1, 32'h3FFF_FFFF, 0, 0);
		run_ins(1, 32'h4000_0000, 0, 0);
		run_ins(1, 32'h7FFF_FFFF, 0, 0);
		run_ins(1, {KIND_PRIM, 20'd0, P_DIV}, 1, 0);
		run_ins(1, {KIND_PRIM, 20'hFFFFF, P_HWIO}, 1, 0);
		run_ins(1, {KIND_PRIM, 20'd0, P_HWIO}, 1, 1);
		run_ins(1, {KIND_PRIM, 20'd0, P_HWIO}, 1, 2);
		run_ins(1, {KIND_PRIM, 20'd0, P_HWIO}, 1, 3);
		run_ins(1, {KIND_PRIM, 20'd0, 8'hFF}, 0, 0);
		run_ins(1, {KIND_CALL, 28'h0FF_FFFC}, 0, 0);
		run_ins(1, {KIND_PRIM, 20'd0, P_RET}, 0, 0);
		run_ins(1, {KIND_BZERO, 28'd8}, 1, 0);
		run_ins(1, {KIND_PRIM, 20'd0, P_FETCH}, 1, 32'h0000_0003);
		run_ins(1, {KIND_PRIM, 20'd0, P_DUP}, 0, 0);
		send(ACT_READ, 20'h00008, $urandom);
		restart();

		rand_loop(PER_LOOP);
		new_setting(21'd0, 21'd1048576, 20'd1, 8'd1);
		rand_loop(PER_LOOP);
		new_setting(21'd1048576, 21'd0, 20'd1048575, 8'd255);
		steady = 1'b1;
		rand_loop(PER_LOOP);
		new_setting(21'($urandom), 21'($urandom), 20'($urandom_range(2, 9)),
			8'($urandom_range(1, 255)));
		steady = 1'b0;
		rand_loop(PER_LOOP);
		wait_quiet();

		$display("sent %0d command words (%0d executes), checked %0d results",
			n_cmds, n_exec, n_checked);
		$display("results with halt: %0d, with frame mark: %0d", n_halts, n_frames);
		if (errors == 0) begin
			$display("[forth_stack_cpu_step_top] OK");
		end else begin
			$display("[forth_stack_cpu_step_top] ERROR");
		end
		$finish;
	end

endmodule
